### sv/sukt_pkg.sv
// Package for the sorted unique key table: sizes, status codes, shared types.
// Used by every module of the block except sukt_ram; depends on nothing.

package sukt_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int KEY_W = 32;
    localparam int ATTR_W = 32;

    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_DUPLICATE = 3'd1;
    localparam logic [2:0] ST_FOUND     = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_LOOKUP = 1'b1;

    // one stored entry, as held in the table RAM
    typedef struct packed {
        logic              kind;
        logic [ATTR_W-1:0] attr;
        logic [KEY_W-1:0]  key;
    } t_entry;

    typedef struct packed {
        logic              req_type;
        logic [KEY_W-1:0]  key;
        logic              kind;
        logic [ATTR_W-1:0] attr;
    } t_req;

    typedef struct packed {
        logic [2:0]        status;
        logic [CNT_W-1:0]  position;
        logic              found_kind;
        logic [ATTR_W-1:0] found_attr;
        logic [CNT_W-1:0]  entry_count;
    } t_rsp;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        t_entry           wdata;
        logic [IDX_W-1:0] raddr;
    } t_ram_req;

    typedef struct packed {
        logic eq;
        logic lt;   // probe key below stored key, signed order
    } t_cmp_res;

    // counts are reported in five bits, masked for large tables
    function automatic logic [4:0] fit5(input logic [CNT_W-1:0] v);
        logic [CNT_W+4:0] w;
        begin
            w = {5'b0, v};
            return w[4:0];
        end
    endfunction

endpackage

### sv/sukt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.

module sukt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### sv/sukt_cmp.sv
// Shared key comparator: equality and signed less-than of probe vs stored key.
// Depends on sukt_pkg.

module sukt_cmp
    import sukt_pkg::*;
(
    input  logic [KEY_W-1:0] i_probe,
    input  logic [KEY_W-1:0] i_stored,
    output t_cmp_res         o_res
);

    always_comb begin
        o_res.eq = (i_probe == i_stored);
        o_res.lt = ($signed(i_probe) < $signed(i_stored));
    end

endmodule

### sv/sukt_ctrl.sv
// Sequencer for the key table: linear scan through the RAM, then shift-up insert.
// Depends on sukt_pkg; drives sukt_ram and sukt_cmp from the top level.

module sukt_ctrl
    import sukt_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_req_valid,
    output logic     o_req_ready,
    input  t_req     i_req,
    output logic     o_rsp_valid,
    input  logic     i_rsp_ready,
    output t_rsp     o_rsp,
    output t_ram_req o_ram,
    input  t_entry   i_ram_rdata,
    output logic [KEY_W-1:0] o_cmp_probe,
    output logic [KEY_W-1:0] o_cmp_stored,
    input  t_cmp_res i_cmp
);

    typedef enum logic [2:0] {
        S_IDLE, S_RD, S_CMP, S_MISS, S_SH_RD, S_SH_WR, S_PUT, S_DONE
    } t_state;

    t_state            r_state, n_state;
    t_req              r_req, n_req;
    logic [CNT_W-1:0]  r_idx, n_idx;
    logic [CNT_W-1:0]  r_ins, n_ins;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [2:0]        r_status, n_status;
    logic [CNT_W-1:0]  r_pos, n_pos;
    logic              r_fkind, n_fkind;
    logic [ATTR_W-1:0] r_fattr, n_fattr;
    logic [CNT_W-1:0]  idx_dec;

    assign idx_dec      = r_idx - CNT_W'(1);
    assign o_cmp_probe  = r_req.key;
    assign o_cmp_stored = i_ram_rdata.key;

    always_comb begin
        o_req_ready = (r_state == S_IDLE);
        o_rsp_valid = (r_state == S_DONE);
        o_rsp.status      = r_status;
        o_rsp.position    = r_pos;
        o_rsp.found_kind  = r_fkind;
        o_rsp.found_attr  = r_fattr;
        o_rsp.entry_count = r_count;

        o_ram.we         = 1'b0;
        o_ram.waddr      = r_idx[IDX_W-1:0];
        o_ram.wdata      = i_ram_rdata;
        o_ram.raddr      = r_idx[IDX_W-1:0];
        if (r_state == S_SH_RD) begin
            o_ram.raddr = idx_dec[IDX_W-1:0];
        end
        if (r_state == S_SH_WR) begin
            o_ram.we = 1'b1;
        end
        if (r_state == S_PUT) begin
            o_ram.we         = 1'b1;
            o_ram.waddr      = r_ins[IDX_W-1:0];
            o_ram.wdata.key  = r_req.key;
            o_ram.wdata.kind = r_req.kind;
            o_ram.wdata.attr = r_req.attr;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_req    = r_req;
        n_idx    = r_idx;
        n_ins    = r_ins;
        n_count  = r_count;
        n_status = r_status;
        n_pos    = r_pos;
        n_fkind  = r_fkind;
        n_fattr  = r_fattr;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_req   = i_req;
                    n_idx   = '0;
                    n_ins   = r_count;
                    n_fkind = 1'b0;
                    n_fattr = '0;
                    n_state = (r_count == '0) ? S_MISS : S_RD;
                end
            end
            S_RD: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                if (i_cmp.eq) begin
                    n_pos    = r_idx;
                    n_fkind  = i_ram_rdata.kind;
                    n_fattr  = i_ram_rdata.attr;
                    n_status = (r_req.req_type == REQ_INSERT) ? ST_DUPLICATE : ST_FOUND;
                    n_state  = S_DONE;
                end else if (i_cmp.lt) begin
                    // table is sorted: first larger key ends the search
                    n_ins   = r_idx;
                    n_state = S_MISS;
                end else if (r_idx + CNT_W'(1) == r_count) begin
                    n_ins   = r_count;
                    n_state = S_MISS;
                end else begin
                    n_idx   = r_idx + CNT_W'(1);
                    n_state = S_RD;
                end
            end
            S_MISS: begin
                n_pos = r_count;
                if (r_req.req_type == REQ_LOOKUP) begin
                    n_status = ST_NOT_FOUND;
                    n_state  = S_DONE;
                end else if (r_count == CNT_W'(DEPTH)) begin
                    n_status = ST_FULL;
                    n_state  = S_DONE;
                end else begin
                    n_idx   = r_count;
                    n_state = (r_count == r_ins) ? S_PUT : S_SH_RD;
                end
            end
            S_SH_RD: begin
                n_state = S_SH_WR;
            end
            S_SH_WR: begin
                n_idx   = idx_dec;
                n_state = (idx_dec == r_ins) ? S_PUT : S_SH_RD;
            end
            S_PUT: begin
                n_count  = r_count + CNT_W'(1);
                n_status = ST_INSERTED;
                n_state  = S_DONE;
            end
            S_DONE: begin
                if (i_rsp_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_req    <= n_req;
        r_idx    <= n_idx;
        r_ins    <= n_ins;
        r_status <= n_status;
        r_pos    <= n_pos;
        r_fkind  <= n_fkind;
        r_fattr  <= n_fattr;
    end

endmodule

### sv/sorted_unique_key_table_unit.sv
// Top level of the sorted unique key table: stream ports and result register.
// Depends on sukt_pkg, sukt_ram, sukt_cmp and sukt_ctrl.
//
// Usage
//  - Requests arrive on the s_axis channel: tuser selects insert (0) or
//    lookup (1); tdata carries key, kind and attribute.
//  - Each request gives exactly one result transaction on m_axis: tuser
//    carries the status, tdata position, matched payload and entry count.
//  - Entries sit in one RAM in ascending signed key order. A request scans
//    it from index 0, one entry at a time (a read state, then a compare
//    state) through a single comparator, stopping at the first key that is equal or larger.
//  - An insert then moves the larger entries up one place, each with a read
//    and a write over the single RAM port pair, and writes the new entry.
//  - s_axis_tready is high only while no request is in progress; one
//    request is handled at a time, and the next one can be accepted as soon
//    as the result has moved into the output register.
//  - The result sits in an output register. The next request is accepted
//    while it waits; a finished result stalls the sequencer only until the
//    register frees up.
//  - Reset (synchronous, active low) empties the table and drops any
//    pending result; RAM contents are not cleared.

module sorted_unique_key_table_unit
    import sukt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,  // part_key[31:0], part_kind[32], attribute[64:33], 0
    input  logic        s_axis_tuser,  // req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,  // position[4:0], found_kind[5],
                                       // found_attribute[37:6], entry_count[42:38], 0
    output logic [2:0]  m_axis_tuser   // status
);

    t_req     req;
    t_rsp     rsp;
    t_ram_req ram_req;
    t_entry   ram_rdata;
    t_cmp_res cmp_res;
    logic [KEY_W-1:0] cmp_probe;
    logic [KEY_W-1:0] cmp_stored;
    logic     rsp_valid;
    logic     rsp_ready;

    logic        r_out_valid;
    logic [47:0] r_out_data;
    logic [2:0]  r_out_user;

    assign req.req_type = s_axis_tuser;
    assign req.key      = s_axis_tdata[31:0];
    assign req.kind     = s_axis_tdata[32];
    assign req.attr     = s_axis_tdata[64:33];

    // the output register takes a result when empty or being drained
    assign rsp_ready = !r_out_valid || m_axis_tready;

    sukt_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (s_axis_tvalid),
        .o_req_ready  (s_axis_tready),
        .i_req        (req),
        .o_rsp_valid  (rsp_valid),
        .i_rsp_ready  (rsp_ready),
        .o_rsp        (rsp),
        .o_ram        (ram_req),
        .i_ram_rdata  (ram_rdata),
        .o_cmp_probe  (cmp_probe),
        .o_cmp_stored (cmp_stored),
        .i_cmp        (cmp_res)
    );

    sukt_cmp u_cmp (
        .i_probe  (cmp_probe),
        .i_stored (cmp_stored),
        .o_res    (cmp_res)
    );

    sukt_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_raddr (ram_req.raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (rsp_valid && rsp_ready) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (rsp_valid && rsp_ready) begin
            r_out_user <= rsp.status;
            r_out_data <= {5'b0, fit5(rsp.entry_count), rsp.found_attr,
                           rsp.found_kind, fit5(rsp.position)};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

endmodule

### sv/sukt_chk.sv
// Port-level checker for the sorted unique key table, bound to the top level.
// Depends on sukt_pkg.

module sukt_chk
    import sukt_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // a stalled result keeps its content
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // one request at a time: busy right after a transaction
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request taken while busy");

    // no payload reported unless a key matched
    a_zero_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == ST_INSERTED || m_axis_tuser == ST_NOT_FOUND
                          || m_axis_tuser == ST_FULL) |-> m_axis_tdata[37:5] == '0)
        else $error("payload on a miss");

endmodule

bind sorted_unique_key_table_unit sukt_chk u_chk (.*);
